>>> sv/kmp_stream_matcher_macros.svh
// assertion macros for the kmp stream matcher
`ifndef KMP_STREAM_MATCHER_MACROS_SVH
`define KMP_STREAM_MATCHER_MACROS_SVH

// implication checked every clock, quiet during reset
`define KMP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmp assertion failed");

// next-cycle implication, quiet during reset
`define KMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmp assertion failed");

`endif

>>> sv/kmp_pkg.sv
// shared types and constants for the kmp stream matcher
package kmp_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_NEWTXT = 2'd3
    } t_op;

    localparam int unsigned CountW = 16;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
    } t_in;

    typedef struct packed {
        logic              match_here;
        logic [CountW-1:0] match_count;
        logic              found;
        logic              status;
    } t_out;

endpackage

>>> sv/kmp_cell.sv
// one cell of the matcher chain: a pattern char and its prefix-match bit
module kmp_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic       i_newtxt,
    input  logic       i_append,
    input  logic       i_text,
    input  logic [7:0] i_ch,
    input  logic       i_prev_used,
    input  logic       i_prev_m,
    input  logic       i_next_used,
    output logic       o_used,
    output logic       o_m,
    output logic       o_hit
);
    logic [7:0] r_pch;
    logic       r_used, r_m;
    logic       w_ext, w_last, w_take;

    // prefix one char longer than the neighbor's still ends the text
    assign w_ext  = i_prev_m && r_used && (r_pch == i_ch);
    // this cell holds the final pattern char
    assign w_last = r_used && !i_next_used;
    // first free cell takes the appended char
    assign w_take = i_append && i_prev_used && !r_used;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pch <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_used <= 1'b0;
            r_m    <= 1'b0;
        end else begin
            if (w_take) begin
                r_used <= 1'b1;
            end
            if (i_newtxt) begin
                r_m <= 1'b0;
            end else if (i_text) begin
                // a full match is not kept, like the failure-link fall-back
                r_m <= w_ext && !w_last;
            end
        end
    end

    assign o_used = r_used;
    assign o_m    = r_m;
    assign o_hit  = w_ext && w_last;
endmodule

>>> sv/kmp_stream_matcher.sv
// top level of the kmp stream matcher
// Knuth-Morris-Pratt matcher over 8-bit chars. Issue a transaction with start while busy
// is low; its result appears on o_done for exactly one cycle and cannot be held off.
// For each transaction, the accept edge latches it and raises busy, the
// next edge executes it in the cell chain and registers the result, which is strobed
// on o_done in the following cycle. Busy is low again in that cycle, so the next
// transaction can be accepted at the edge that ends the result cycle. Nothing stalls:
// instead of walking failure links one hop at a time, cell k keeps a bit that says
// whether the pattern prefix of length k+1 ends the text so far, and all cells step
// together from their neighbor's bit. Those bits are exactly the prefixes a failure-link
// walk would visit. A full match is not carried forward, as in the fall-back to the
// failure link of the whole pattern, so an append during text continues from the same
// partial match. An empty pattern matches every text char, appends past MAX_PATTERN
// are dropped and flagged in status, and the occurrence count saturates.
`include "kmp_stream_matcher_macros.svh"
module kmp_stream_matcher #(
    parameter int unsigned MAX_PATTERN = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  kmp_pkg::t_in  i_item,
    output logic          o_done,
    output kmp_pkg::t_out o_result
);
    localparam logic [kmp_pkg::CountW-1:0] CMAX = '1;
    localparam logic [kmp_pkg::CountW-1:0] CNT_ONE = {{(kmp_pkg::CountW-1){1'b0}}, 1'b1};

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state        r_state;
    kmp_pkg::t_op  r_op;
    logic [7:0]    r_ch;
    logic [kmp_pkg::CountW-1:0] r_cnt, n_cnt;
    logic          r_hit, r_status;

    // chain taps, bit k belongs to cell k
    logic [MAX_PATTERN-1:0] w_used, w_m, w_hit;
    logic          w_exec, w_clear, w_append, w_text, w_newtxt;
    logic          w_full, w_hit_any;

    assign w_exec = (r_state == S_EXEC);

    // op decode for the executing transaction and the next occurrence count
    always_comb begin
        w_clear  = 1'b0;
        w_append = 1'b0;
        w_text   = 1'b0;
        w_newtxt = 1'b0;
        n_cnt    = r_cnt;
        unique case (r_op)
            kmp_pkg::OP_CLEAR: begin
                w_clear = w_exec;
                n_cnt   = '0;
            end
            kmp_pkg::OP_APPEND: w_append = w_exec;
            kmp_pkg::OP_TEXT: begin
                w_text = w_exec;
                if (w_hit_any && r_cnt != CMAX) n_cnt = r_cnt + CNT_ONE;
            end
            kmp_pkg::OP_NEWTXT: begin
                w_newtxt = w_exec;
                n_cnt    = '0;
            end
        endcase
    end

    // cell k holds pattern char k; chain links pass used and match bits
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic w_pu, w_pm, w_nu;
        if (k == 0) begin : g_head
            // the empty prefix always matches
            assign w_pu = 1'b1;
            assign w_pm = 1'b1;
        end else begin : g_body
            assign w_pu = w_used[k-1];
            assign w_pm = w_m[k-1];
        end
        if (k == MAX_PATTERN - 1) begin : g_tail
            assign w_nu = 1'b0;
        end else begin : g_next
            assign w_nu = w_used[k+1];
        end
        kmp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clear    (w_clear),
            .i_newtxt   (w_newtxt),
            .i_append   (w_append),
            .i_text     (w_text),
            .i_ch       (r_ch),
            .i_prev_used(w_pu),
            .i_prev_m   (w_pm),
            .i_next_used(w_nu),
            .o_used     (w_used[k]),
            .o_m        (w_m[k]),
            .o_hit      (w_hit[k])
        );
    end

    // store is full once the last cell holds a char
    assign w_full    = w_used[MAX_PATTERN-1];
    // an empty pattern matches at every char
    assign w_hit_any = !w_used[0] || (|w_hit);

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= kmp_pkg::OP_CLEAR;
            r_ch     <= '0;
            r_cnt    <= '0;
            r_hit    <= 1'b0;
            r_status <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    o_done <= 1'b0;
                    if (start) begin
                        r_op    <= kmp_pkg::t_op'(i_item.op);
                        r_ch    <= i_item.ch;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // cells step on this same edge
                    r_hit    <= (r_op == kmp_pkg::OP_TEXT) && w_hit_any;
                    r_status <= (r_op == kmp_pkg::OP_APPEND) && w_full;
                    r_cnt    <= n_cnt;
                    o_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_result.match_here  = r_hit;
        o_result.match_count = r_cnt;
        o_result.found       = (r_cnt != '0);
        o_result.status      = r_status;
    end

    `KMP_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    `KMP_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `KMP_ASSERT_IMPL(a_used_packed, i_clk, i_rst_n, 1'b1, (w_used & (w_used + MAX_PATTERN'(1))) == '0)
    `KMP_ASSERT_IMPL(a_m_in_pattern, i_clk, i_rst_n, 1'b1, (w_m & ~w_used) == '0)
endmodule

>>> bench/kmp_stream_matcher_tb.sv
// self-checking testbench for the kmp stream matcher
module kmp_stream_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PatCap = 256;
    localparam int CountMax = 65535;
    localparam int StallLimit = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    kmp_pkg::t_in i_item = '0;
    logic o_done;
    kmp_pkg::t_out o_result;

    kmp_stream_matcher #(.MAX_PATTERN(PatCap)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result)
    );

    always #10 i_clk = ~i_clk;

    // predictor state: pattern store, failure links and match progress
    logic [7:0] pat_mem [PatCap];
    int link_mem [PatCap+1];
    int pat_len, build_pos, text_pos;
    int unsigned occ_cnt;

    kmp_pkg::t_in item_q [$];    // transactions waiting to be issued
    int gap_q [$];               // idle cycles before each transaction
    kmp_pkg::t_out result_q [$]; // expected results, oldest first
    int err_cnt = 0;
    int quiet_cycles = 0;
    bit took = 1'b0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic void clear_all();
        for (int i = 0; i <= PatCap; i++) link_mem[i] = 0;
        link_mem[0] = -1;
        pat_len = 0;
        build_pos = -1;
        text_pos = 0;
        occ_cnt = 0;
    endfunction

    // follow failure links until c extends the prefix or the marker is hit
    function automatic int follow_links(input int pos, input logic [7:0] c);
        while (pos >= 0 && pos < pat_len && pat_mem[pos] != c) pos = link_mem[pos];
        if (pos >= pat_len) pos = -1;
        return pos;
    endfunction

    function automatic kmp_pkg::t_out match_step(input kmp_pkg::t_in it);
        kmp_pkg::t_out r;
        int j;
        r = '0;
        case (kmp_pkg::t_op'(it.op))
            kmp_pkg::OP_CLEAR: clear_all();
            kmp_pkg::OP_APPEND: begin
                if (pat_len >= PatCap) begin
                    r.status = 1'b1;
                end else begin
                    pat_mem[pat_len] = it.ch;
                    pat_len++;
                    build_pos = follow_links(build_pos, it.ch) + 1;
                    link_mem[pat_len] = build_pos;
                end
            end
            kmp_pkg::OP_TEXT: begin
                if (pat_len == 0) begin
                    r.match_here = 1'b1;
                end else begin
                    j = follow_links(text_pos, it.ch) + 1;
                    if (j >= pat_len) begin
                        r.match_here = 1'b1;
                        j = link_mem[pat_len];
                    end
                    if (j < 0 || j >= pat_len) j = 0;
                    text_pos = j;
                end
                if (r.match_here && occ_cnt < CountMax) occ_cnt++;
            end
            default: begin
                text_pos = 0;
                occ_cnt = 0;
            end
        endcase
        r.match_count = occ_cnt[15:0];
        r.found = (occ_cnt != 0);
        return r;
    endfunction

    // issue helpers for the stimulus builder
    task automatic push_op(input kmp_pkg::t_op op, input logic [7:0] c, input bit may_idle);
        kmp_pkg::t_in it;
        it.op = op;
        it.ch = c;
        item_q.push_back(it);
        gap_q.push_back((may_idle && $urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
    endtask

    // checker and acceptance, both at the rising edge
    always @(posedge i_clk) begin
        kmp_pkg::t_out want;
        took = i_rst_n && start && !busy;
        if (i_rst_n && o_done) begin
            if (result_q.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                want = result_q.pop_front();
                if (o_result.match_here !== want.match_here)
                    report("match_here", int'(o_result.match_here), int'(want.match_here));
                if (o_result.match_count !== want.match_count)
                    report("match_count", int'(o_result.match_count),
                           int'(want.match_count));
                if (o_result.found !== want.found)
                    report("found", int'(o_result.found), int'(want.found));
                if (o_result.status !== want.status)
                    report("status", int'(o_result.status), int'(want.status));
            end
        end
        if (took) result_q.push_back(match_step(i_item));
        // watchdog on cycles where no transaction is accepted
        if (!i_rst_n || took || (item_q.size() == 0 && result_q.size() == 0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
            $display("kmp_stream_matcher_tb: done, errors");
            $finish;
        end
    end

    // driver: new transaction or idle at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took)) begin
            if (gap_q.size() != 0 && gap_q[0] > 0) begin
                gap_q[0]--;
                start <= 1'b0;
            end else if (item_q.size() != 0) begin
                void'(gap_q.pop_front());
                i_item <= item_q.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    initial begin
        logic [7:0] alpha [2];
        int n, plen, tlen, total;
        clear_all();

        // directed: empty pattern, extremes of ch, every op, store full later
        push_op(kmp_pkg::OP_TEXT, 8'h00, 0);
        push_op(kmp_pkg::OP_TEXT, 8'hff, 1);
        push_op(kmp_pkg::OP_NEWTXT, 8'h5a, 0);
        push_op(kmp_pkg::OP_APPEND, 8'h00, 1);
        push_op(kmp_pkg::OP_APPEND, 8'hff, 0);
        push_op(kmp_pkg::OP_APPEND, 8'h00, 0);
        push_op(kmp_pkg::OP_TEXT, 8'h00, 0);
        push_op(kmp_pkg::OP_TEXT, 8'hff, 1);
        push_op(kmp_pkg::OP_TEXT, 8'h00, 0);   // overlapping occurrence next
        push_op(kmp_pkg::OP_TEXT, 8'hff, 0);
        push_op(kmp_pkg::OP_TEXT, 8'h00, 0);
        push_op(kmp_pkg::OP_APPEND, 8'hff, 0); // append with a partial match in progress
        push_op(kmp_pkg::OP_TEXT, 8'hff, 0);
        push_op(kmp_pkg::OP_TEXT, 8'h00, 1);
        push_op(kmp_pkg::OP_NEWTXT, 8'h00, 0);
        push_op(kmp_pkg::OP_TEXT, 8'h00, 0);
        push_op(kmp_pkg::OP_CLEAR, 8'hff, 0);
        push_op(kmp_pkg::OP_TEXT, 8'h7e, 0);

        // random sessions: clear or new text, build a small pattern, stream matching text
        total = 0;
        while (total < 1100) begin
            alpha[0] = 8'($urandom_range(255));
            alpha[1] = $urandom_range(3) == 0 ? 8'($urandom_range(255)) : ~alpha[0];
            push_op($urandom_range(1) ? kmp_pkg::OP_CLEAR : kmp_pkg::OP_NEWTXT,
                    8'($urandom_range(255)), 1);
            plen = $urandom_range(9) == 0 ? 0 : $urandom_range(1, 7);
            for (int i = 0; i < plen; i++)
                push_op(kmp_pkg::OP_APPEND, alpha[$urandom_range(1)], 1);
            tlen = $urandom_range(10, 50);
            for (int i = 0; i < tlen; i++) begin
                n = $urandom_range(19);
                if (n == 0)
                    push_op(kmp_pkg::OP_APPEND, alpha[$urandom_range(1)], 1);
                else if (n == 1)
                    push_op(kmp_pkg::t_op'($urandom_range(3)), 8'($urandom_range(255)), 1);
                else if (n == 2)
                    push_op(kmp_pkg::OP_TEXT, 8'($urandom_range(255)), 1);
                else
                    push_op(kmp_pkg::OP_TEXT, alpha[$urandom_range(1)], 1);
            end
            total += 1 + plen + tlen;
        end

        // fill the store with a periodic pattern, overflow it, then match
        push_op(kmp_pkg::OP_CLEAR, 8'h00, 1);
        for (int i = 0; i < PatCap + 3; i++)
            push_op(kmp_pkg::OP_APPEND, (i % 7 == 6) ? 8'hb5 : 8'h4a, 1);
        for (int i = 0; i < 300; i++)
            push_op(kmp_pkg::OP_TEXT, (i % 7 == 6) ? 8'hb5 : 8'h4a, 1);

        // last part, no idling: an empty pattern matches every char
        push_op(kmp_pkg::OP_CLEAR, 8'h00, 0);
        for (int i = 0; i < 100; i++)
            push_op(kmp_pkg::OP_TEXT, 8'($urandom_range(255)), 0);
        push_op(kmp_pkg::OP_NEWTXT, 8'h00, 0);

        // hold reset low, then release it at a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (item_q.size() != 0 || start || result_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("kmp_stream_matcher_tb: done, clean");
        else
            $display("kmp_stream_matcher_tb: done, errors");
        $finish;
    end

endmodule
